[rtl/smpq_pkg.sv]
// ----------------------------------------------------------------------------
// smpq_pkg: shared definitions for the sorted min-first priority queue
// Holds the queue depth, field widths, operation codes and the control word
// that the top level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package smpq_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned ValW     = 32;
  localparam int unsigned HeldW    = $clog2(Capacity + 1);
  localparam int unsigned CountW   = 5;

  typedef enum logic [1:0] {
    ModeEnq   = 2'd0,
    ModeDeq   = 2'd1,
    ModePeek  = 2'd2,
    ModeClear = 2'd3
  } mode_e;

  // Control word seen by all cells in the same cycle.
  typedef struct packed {
    logic                   enq;     // insert new_val at its sorted place
    logic                   deq;     // every cell takes its right neighbor
    logic signed [ValW-1:0] new_val;
  } cell_ctrl_t;

endpackage

[rtl/smpq_cell.sv]
// ----------------------------------------------------------------------------
// smpq_cell: one slot of the sorted chain
// Holds one value. On insert it either keeps its value, takes the new value,
// or takes its left neighbor's value; on removal it takes its right neighbor's.
// ----------------------------------------------------------------------------
module smpq_cell (
  input  logic                            clk_i,
  input  smpq_pkg::cell_ctrl_t            ctrl_i,
  input  logic                            valid_i,
  input  logic                            left_take_i,
  input  logic signed [smpq_pkg::ValW-1:0] left_val_i,
  input  logic signed [smpq_pkg::ValW-1:0] right_val_i,
  output logic                            take_o,
  output logic signed [smpq_pkg::ValW-1:0] val_o
);

  logic signed [smpq_pkg::ValW-1:0] val_q;
  logic signed [smpq_pkg::ValW-1:0] val_d;

  // This slot lies at or after the insert point when it is empty or holds a
  // strictly greater value, so equal values stay ahead of the newcomer.
  assign take_o = !valid_i || (val_q > ctrl_i.new_val);
  assign val_o  = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.enq) begin
      if (left_take_i) begin
        val_d = left_val_i;
      end else if (take_o) begin
        val_d = ctrl_i.new_val;
      end
    end else if (ctrl_i.deq) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

[rtl/sorted_min_priority_queue_unit.sv]
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_unit: bounded min-first priority queue
// Keeps up to Capacity signed values in ascending order in a chain of cells
// and answers enqueue, dequeue, peek and clear with one result word each.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | tdata (low bit up)                    | tuser
//  ---------+-----------+---------------------------------------+-----------
//  s_axis   | in        | value_in[31:0]                        | mode[1:0]
//  m_axis   | out       | value_out[31:0], count[36:32],        | error[0]
//           |           | empty_res[37], zero pad [39:38]       |
//
//  The whole chain of cells updates at the edge that accepts an operation word,
//  so a new word is taken every cycle unless the input side stalls as below.
//  The result is registered and appears in the cycle after acceptance.
//  The input side stalls only while a result waits and m_axis_tready_i is low.
//  Reset clears the fill count and the output valid; the cell values are
//  left as they are, since only slots below the fill count are ever read.
//
module sorted_min_priority_queue_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Operation words.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // value_in[31:0]
  input  logic [1:0]  s_axis_tuser_i,   // mode[1:0]
  // Result words.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // value_out[31:0], count[36:32], empty_res[37]
  output logic [0:0]  m_axis_tuser_o    // error[0]
);

  localparam int unsigned Cap   = smpq_pkg::Capacity;
  localparam int unsigned ValW  = smpq_pkg::ValW;
  localparam int unsigned HeldW = smpq_pkg::HeldW;

  // Fill count and output register.
  logic [HeldW-1:0]       held_q, held_d;
  logic                   out_valid_q;
  logic signed [ValW-1:0] out_val_q, out_val_d;
  logic                   out_err_q, out_err_d;
  logic [HeldW-1:0]       out_held_q;

  logic                 accept;
  smpq_pkg::mode_e      mode;
  logic signed [ValW-1:0] new_val;
  logic                 is_full;
  logic                 is_empty;
  smpq_pkg::cell_ctrl_t ctrl;

  // Chain wiring.
  logic                   take   [Cap];
  logic signed [ValW-1:0] val    [Cap];
  logic                   valid  [Cap];
  logic                   left_take [Cap];
  logic signed [ValW-1:0] left_val  [Cap];
  logic signed [ValW-1:0] right_val [Cap];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign mode            = smpq_pkg::mode_e'(s_axis_tuser_i);
  assign new_val         = $signed(s_axis_tdata_i);
  assign is_full         = (held_q == HeldW'(Cap));
  assign is_empty        = (held_q == '0);

  assign ctrl.enq     = accept && (mode == smpq_pkg::ModeEnq) && !is_full;
  assign ctrl.deq     = accept && (mode == smpq_pkg::ModeDeq) && !is_empty;
  assign ctrl.new_val = new_val;

  // Each cell sees its neighbors; the ends see themselves, with no take from the left,
  // which means cell zero never takes a left neighbor's value and the last cell keeps
  // its own value after a removal (the fill count then excludes it).
  for (genvar i = 0; i < Cap; i++) begin : g_cell
    assign valid[i] = (HeldW'(i) < held_q);
    if (i == 0) begin : g_first
      assign left_take[i] = 1'b0;
      assign left_val[i]  = val[i];
    end else begin : g_mid
      assign left_take[i] = take[i-1];
      assign left_val[i]  = val[i-1];
    end
    if (i == Cap - 1) begin : g_last
      assign right_val[i] = val[i];
    end else begin : g_inner
      assign right_val[i] = val[i+1];
    end

    smpq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .valid_i     (valid[i]),
      .left_take_i (left_take[i]),
      .left_val_i  (left_val[i]),
      .right_val_i (right_val[i]),
      .take_o      (take[i]),
      .val_o       (val[i])
    );
  end

  // Result and next fill count. After an insert the head is the new value
  // exactly when the head slot takes it (empty queue or smaller value).
  always_comb begin
    held_d    = held_q;
    out_val_d = '1;
    out_err_d = 1'b0;
    unique case (mode)
      smpq_pkg::ModeEnq: begin
        if (is_full) begin
          out_err_d = 1'b1;
          out_val_d = val[0];
        end else begin
          held_d    = held_q + HeldW'(1);
          out_val_d = take[0] ? new_val : val[0];
        end
      end
      smpq_pkg::ModeDeq: begin
        if (is_empty) begin
          out_err_d = 1'b1;
        end else begin
          held_d    = held_q - HeldW'(1);
          out_val_d = val[0];
        end
      end
      smpq_pkg::ModePeek: begin
        if (is_empty) begin
          out_err_d = 1'b1;
        end else begin
          out_val_d = val[0];
        end
      end
      smpq_pkg::ModeClear: begin
        held_d = '0;
      end
      default: begin
        held_d = held_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        held_q      <= held_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload of the result register needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_val_q  <= out_val_d;
      out_err_q  <= out_err_d;
      out_held_q <= held_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, (out_held_q == '0),
                            smpq_pkg::CountW'(out_held_q), out_val_q};
  assign m_axis_tuser_o  = out_err_q;

endmodule
